// ===== rtl/core/wcs_pkg.sv =====
// ----------------------------------------------------------------------------
// wcs_pkg
// Shared types and constants of the wheel cipher substitution block: field
// widths, register indexes, reset values and the items passed between parts.
// ----------------------------------------------------------------------------
package wcs_pkg;

    localparam int CHAR_W      = 16;
    localparam int SHIFT_W     = 5;
    localparam int ALPHA_W     = 6;
    localparam int DCOUNT_W    = 5;
    localparam int CFG_DATA_W  = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int DISK_IDX_W  = 4;
    localparam int SLOT_IDX_W  = 5;

    // Widest disk and slot numbers any configuration of the block can use
    localparam int ITEM_DISK_W = 8;
    localparam int ITEM_SLOT_W = 6;

    localparam int MID_DEPTH   = 4;
    localparam int OUT_DEPTH   = 8;

    localparam logic OP_CIPHER = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SHIFT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHABET  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DCOUNT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT   = 2'd3;

    localparam logic [SHIFT_W-1:0]  RST_SHIFT    = 5'd0;
    localparam logic [ALPHA_W-1:0]  RST_ALPHABET = 6'd26;
    localparam logic [DCOUNT_W-1:0] RST_DCOUNT   = 5'd1;
    localparam logic                RST_DECRYPT  = 1'b0;

    typedef struct packed {
        logic [SHIFT_W-1:0]  shift;
        logic [ALPHA_W-1:0]  alphabet_size;
        logic [DCOUNT_W-1:0] disk_total;
        logic                decrypt_mode;
    } cfg_t;

    typedef struct packed {
        logic                   is_cipher;
        logic                   wr_en;
        logic [ITEM_DISK_W-1:0] disk;
        logic [ITEM_SLOT_W-1:0] slot;
        logic [CHAR_W-1:0]      ch;
    } item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              not_found;
    } res_t;

endpackage

// ===== rtl/core/wcs_fifo.sv =====
// ----------------------------------------------------------------------------
// wcs_fifo
// Small synchronous queue with occupancy count; head is read directly.
// ----------------------------------------------------------------------------
module wcs_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    output logic                       full,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNTW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_mem[rd_ptr_reg];
    assign count   = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNTW'(do_push) - CNTW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/core/wcs_front.sv =====
// ----------------------------------------------------------------------------
// wcs_front
// Request intake: classifies load and cipher requests, tracks the disk
// position and picks the disk for each character.
// ----------------------------------------------------------------------------
module wcs_front #(
    parameter int MAX_DISKS = 16,
    parameter int MAX_SLOTS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  wcs_pkg::cfg_t                        cfg,
    input  logic                                 push,
    input  logic                                 op,
    input  logic [wcs_pkg::DISK_IDX_W-1:0]       disk_index,
    input  logic [wcs_pkg::SLOT_IDX_W-1:0]       slot_index,
    input  logic [wcs_pkg::CHAR_W-1:0]           char_code,
    input  logic                                 restart,
    input  logic                                 q_full,
    output logic                                 q_push,
    output wcs_pkg::item_t                       q_item
);

    localparam int PW = (MAX_DISKS > 1) ? $clog2(MAX_DISKS) : 1;
    localparam int CW = $clog2(MAX_DISKS + 1);
    localparam int RW = PW + CW;

    logic [PW-1:0] pos_reg, pos_next;
    logic [CW-1:0] dc_used;
    logic [RW-1:0] rem;
    logic [PW-1:0] disk;
    logic [CW-1:0] disk_inc;
    logic          is_cipher;
    logic          load_ok;

    assign is_cipher = (op == wcs_pkg::OP_CIPHER);
    assign load_ok   = (32'(disk_index) < MAX_DISKS) && (32'(slot_index) < MAX_SLOTS);
    assign q_push    = push && !q_full;

    // Clamp the disk count into 1..MAX_DISKS
    always_comb
    begin
        priority if (cfg.disk_total == '0)
        begin
            dc_used = CW'(1);
        end
        else if (32'(cfg.disk_total) > MAX_DISKS)
        begin
            dc_used = CW'(MAX_DISKS);
        end
        else
        begin
            dc_used = CW'(cfg.disk_total);
        end
    end

    // Position modulo disk count, one restoring step per position bit
    always_comb
    begin
        rem = restart ? '0 : RW'(pos_reg);
        for (int i = PW - 1; i >= 0; i--)
        begin
            if (rem >= (RW'(dc_used) << i))
            begin
                rem = rem - (RW'(dc_used) << i);
            end
        end
        disk     = rem[PW-1:0];
        disk_inc = CW'(disk) + CW'(1);
        pos_next = (disk_inc == dc_used) ? '0 : PW'(disk_inc);
    end

    always_comb
    begin
        q_item.is_cipher = is_cipher;
        q_item.wr_en     = load_ok;
        q_item.disk      = is_cipher ? wcs_pkg::ITEM_DISK_W'(disk)
                                     : wcs_pkg::ITEM_DISK_W'(disk_index);
        q_item.slot      = wcs_pkg::ITEM_SLOT_W'(slot_index);
        q_item.ch        = char_code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (q_push && is_cipher)
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

// ===== rtl/core/wcs_back.sv =====
// ----------------------------------------------------------------------------
// wcs_back
// Execution pipeline: holds the disk table, writes loads, and for each
// character reads the disk row, matches it, shifts the slot and selects.
// ----------------------------------------------------------------------------
module wcs_back #(
    parameter int MAX_DISKS = 16,
    parameter int MAX_SLOTS = 32
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  wcs_pkg::cfg_t                                cfg,
    input  logic                                         q_empty,
    input  wcs_pkg::item_t                               q_item,
    output logic                                         q_pop,
    input  logic [$clog2(wcs_pkg::OUT_DEPTH+1)-1:0]      out_count,
    output logic                                         res_push,
    output wcs_pkg::res_t                                res
);

    localparam int DAW = (MAX_DISKS > 1) ? $clog2(MAX_DISKS) : 1;
    localparam int SW  = $clog2(MAX_SLOTS);
    localparam int NW  = $clog2(MAX_SLOTS + 1);
    localparam int MW  = wcs_pkg::SHIFT_W + NW;

    typedef logic [MAX_SLOTS-1:0][wcs_pkg::CHAR_W-1:0] row_t;

    row_t table_mem [MAX_DISKS];

    logic                      s1_valid_reg, s2_valid_reg, s3_valid_reg;
    row_t                      s1_row_reg, s2_row_reg, s3_row_reg;
    logic [wcs_pkg::CHAR_W-1:0] s1_ch_reg, s2_ch_reg, s3_ch_reg;
    logic [MAX_SLOTS-1:0]      s2_match_reg;
    logic [SW-1:0]             s3_idx_reg;
    logic                      s3_found_reg;
    logic [SW-1:0]             shm_reg;

    logic [NW-1:0]             n_used;
    logic [MW-1:0]             shm_rem;
    logic                      credit_ok;
    logic [MAX_SLOTS-1:0]      match;
    logic [SW-1:0]             first_idx;
    logic [NW:0]               sum;
    logic [SW-1:0]             new_idx;

    // Clamp the alphabet size into 1..MAX_SLOTS
    always_comb
    begin
        priority if (cfg.alphabet_size == '0)
        begin
            n_used = NW'(1);
        end
        else if (32'(cfg.alphabet_size) > MAX_SLOTS)
        begin
            n_used = NW'(MAX_SLOTS);
        end
        else
        begin
            n_used = NW'(cfg.alphabet_size);
        end
    end

    // Shift modulo alphabet size, one restoring step per shift bit
    always_comb
    begin
        shm_rem = MW'(cfg.shift);
        for (int i = wcs_pkg::SHIFT_W - 1; i >= 0; i--)
        begin
            if (shm_rem >= (MW'(n_used) << i))
            begin
                shm_rem = shm_rem - (MW'(n_used) << i);
            end
        end
    end

    // Take a character only when the result queue has room for everything in flight
    assign credit_ok = (32'(out_count) + 32'(s1_valid_reg) + 32'(s2_valid_reg)
                        + 32'(s3_valid_reg)) < wcs_pkg::OUT_DEPTH;
    assign q_pop     = !q_empty && (!q_item.is_cipher || credit_ok);

    always_comb
    begin
        for (int k = 0; k < MAX_SLOTS; k++)
        begin
            match[k] = (s1_row_reg[k] == s1_ch_reg) && (NW'(k) < n_used);
        end
    end

    // Lowest matching slot wins
    always_comb
    begin
        first_idx = '0;
        for (int k = MAX_SLOTS - 1; k >= 0; k--)
        begin
            if (s2_match_reg[k])
            begin
                first_idx = SW'(k);
            end
        end
    end

    always_comb
    begin
        if (cfg.decrypt_mode)
        begin
            sum = (NW+1)'(s3_idx_reg) + (NW+1)'(n_used) - (NW+1)'(shm_reg);
        end
        else
        begin
            sum = (NW+1)'(s3_idx_reg) + (NW+1)'(shm_reg);
        end
        if (sum >= (NW+1)'(n_used))
        begin
            sum = sum - (NW+1)'(n_used);
        end
        new_idx      = sum[SW-1:0];
        res.char_out = s3_found_reg ? s3_row_reg[new_idx] : s3_ch_reg;
        res.not_found = !s3_found_reg;
    end

    assign res_push = s3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= q_pop && q_item.is_cipher;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && !q_item.is_cipher && q_item.wr_en)
        begin
            table_mem[q_item.disk[DAW-1:0]][q_item.slot[SW-1:0]] <= q_item.ch;
        end
        if (q_pop && q_item.is_cipher)
        begin
            s1_row_reg <= table_mem[q_item.disk[DAW-1:0]];
            s1_ch_reg  <= q_item.ch;
        end
    end

    always_ff @(posedge clk)
    begin
        shm_reg      <= shm_rem[SW-1:0];
        s2_match_reg <= match;
        s2_row_reg   <= s1_row_reg;
        s2_ch_reg    <= s1_ch_reg;
        s3_idx_reg   <= first_idx;
        s3_found_reg <= |s2_match_reg;
        s3_row_reg   <= s2_row_reg;
        s3_ch_reg    <= s2_ch_reg;
    end

    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> (32'(out_count) < wcs_pkg::OUT_DEPTH))
        else $error("result written into a full queue");

    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        (32'($countones({s1_valid_reg, s2_valid_reg, s3_valid_reg})) + 32'(out_count))
            <= wcs_pkg::OUT_DEPTH)
        else $error("results in flight exceed queue space");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !q_item.is_cipher) |=> !s1_valid_reg)
        else $error("load request entered the result pipeline");

endmodule

// ===== rtl/core/wheel_cipher_char_substitution.sv =====
// ----------------------------------------------------------------------------
// wheel_cipher_char_substitution
// Wheel cipher character substitution with loadable disk tables.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle, loads and characters alike; a character
// passes through the request queue and then the row read, match and select
// stages. Input stalls only when the result queue backs up.
// Reset: registers return to defaults, disk position to 0, both queues empty;
// the disk table is not cleared and holds garbage until loaded.
// ----------------------------------------------------------------------------
module wheel_cipher_char_substitution #(
    parameter int MAX_DISKS = 16,
    parameter int MAX_SLOTS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic                               op,
    input  logic [wcs_pkg::DISK_IDX_W-1:0]     disk_index,
    input  logic [wcs_pkg::SLOT_IDX_W-1:0]     slot_index,
    input  logic [wcs_pkg::CHAR_W-1:0]         char_code,
    input  logic                               restart,
    output logic                               empty,
    input  logic                               pop,
    output logic [wcs_pkg::CHAR_W-1:0]         char_out,
    output logic                               not_found,
    input  logic                               cfg_we,
    input  logic [wcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wcs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int ITEM_W = $bits(wcs_pkg::item_t);
    localparam int RES_W  = $bits(wcs_pkg::res_t);

    wcs_pkg::cfg_t  cfg_reg;
    wcs_pkg::item_t front_item;
    wcs_pkg::item_t back_item;
    wcs_pkg::res_t  back_res;
    wcs_pkg::res_t  head_res;

    logic                                    mid_push, mid_pop, mid_full, mid_empty;
    logic [ITEM_W-1:0]                       mid_rdata;
    logic                                    res_push;
    logic [RES_W-1:0]                        out_rdata;
    logic [$clog2(wcs_pkg::OUT_DEPTH+1)-1:0] out_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.shift         <= wcs_pkg::RST_SHIFT;
            cfg_reg.alphabet_size <= wcs_pkg::RST_ALPHABET;
            cfg_reg.disk_total    <= wcs_pkg::RST_DCOUNT;
            cfg_reg.decrypt_mode  <= wcs_pkg::RST_DECRYPT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wcs_pkg::REG_SHIFT:    cfg_reg.shift         <= cfg_data[wcs_pkg::SHIFT_W-1:0];
                wcs_pkg::REG_ALPHABET: cfg_reg.alphabet_size <= cfg_data[wcs_pkg::ALPHA_W-1:0];
                wcs_pkg::REG_DCOUNT:   cfg_reg.disk_total    <= cfg_data[wcs_pkg::DCOUNT_W-1:0];
                wcs_pkg::REG_DECRYPT:  cfg_reg.decrypt_mode  <= cfg_data[0];
                default:               cfg_reg               <= cfg_reg;
            endcase
        end
    end

    wcs_front #(
        .MAX_DISKS (MAX_DISKS),
        .MAX_SLOTS (MAX_SLOTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .push       (push),
        .op         (op),
        .disk_index (disk_index),
        .slot_index (slot_index),
        .char_code  (char_code),
        .restart    (restart),
        .q_full     (mid_full),
        .q_push     (mid_push),
        .q_item     (front_item)
    );

    assign full = mid_full;

    wcs_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (wcs_pkg::MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (front_item),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty),
        .count ()
    );

    assign back_item = wcs_pkg::item_t'(mid_rdata);

    wcs_back #(
        .MAX_DISKS (MAX_DISKS),
        .MAX_SLOTS (MAX_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (mid_empty),
        .q_item    (back_item),
        .q_pop     (mid_pop),
        .out_count (out_count),
        .res_push  (res_push),
        .res       (back_res)
    );

    wcs_fifo #(
        .WIDTH (RES_W),
        .DEPTH (wcs_pkg::OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (back_res),
        .full  (),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty),
        .count (out_count)
    );

    assign head_res  = wcs_pkg::res_t'(out_rdata);
    assign char_out  = head_res.char_out;
    assign not_found = head_res.not_found;

endmodule
